// ===== design/polar_clamp_vector_assert.svh =====
// Assertion macros for the polar clamp vector block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef POLAR_CLAMP_VECTOR_ASSERT_SVH
`define POLAR_CLAMP_VECTOR_ASSERT_SVH

// Consequent checked in the same cycle
`define PCV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pcv_pkg.sv =====
// ----------------------------------------------------------------------------
// pcv_pkg
// Types, constants and tables shared by the polar clamp vector block.
// ----------------------------------------------------------------------------
package pcv_pkg;

    localparam int COORD_W     = 32;  // external coordinate width
    localparam int GUARD_BITS  = 4;   // extra fraction bits in the datapath
    localparam int VW          = 40;  // internal coordinate width
    localparam int ZW          = 34;  // rotation residual angle width
    localparam int N_STAGES    = 16;  // CORDIC iterations
    localparam int STAGE_IDX_W = 5;
    localparam int LEN_CFG_W   = 31;
    localparam int ANG_CFG_W   = 17;
    localparam int ANGLE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH_FLOOR   = 2'd0,
        REG_LENGTH_CEILING = 2'd1,
        REG_ANGLE_LOW      = 2'd2,
        REG_ANGLE_HIGH     = 2'd3
    } cfg_reg_t;

    localparam logic [ANG_CFG_W-1:0] ANGLE_HIGH_RESET = 17'h10000;

    // Word moving through the vectoring cells
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          acc;
    } vec_t;

    // Word moving through the rotating cells
    typedef struct packed {
        logic                 valid;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

    // atan(2^-i) as a 32-bit turn fraction
    function automatic logic [31:0] atan_turn(input logic [STAGE_IDX_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000028;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000002;
            5'd29:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // x after vectoring (2^30, 0); evaluated at elaboration
    function automatic longint cordic_gain_x();
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = longint'(1) << 30;
        y = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
            end else begin
                x = x - dx;
                y = y + dy;
            end
        end
        return x;
    endfunction

    localparam longint GAIN_X     = cordic_gain_x();
    localparam longint INV_K_FULL = ((longint'(1) << 61) + GAIN_X / 2) / GAIN_X;
    localparam logic [31:0] INV_K = INV_K_FULL[31:0];

endpackage

// ===== design/pcv_point_if.sv =====
// ----------------------------------------------------------------------------
// pcv_point_if
// Input channel: absolute point and reference point.
// ----------------------------------------------------------------------------
interface pcv_point_if;
    import pcv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] abs_x;
    logic signed [COORD_W-1:0] abs_y;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;

    modport source (output valid, abs_x, abs_y, ref_x, ref_y, input ready);
    modport sink   (input valid, abs_x, abs_y, ref_x, ref_y, output ready);
endinterface

// ===== design/pcv_result_if.sv =====
// ----------------------------------------------------------------------------
// pcv_result_if
// Output channel: clamped relative vector.
// ----------------------------------------------------------------------------
interface pcv_result_if;
    import pcv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;

    modport source (output valid, out_x, out_y, input ready);
    modport sink   (input valid, out_x, out_y, output ready);
endinterface

// ===== design/pcv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pcv_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface pcv_cfg_if;
    import pcv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pcv_vec_cell.sv =====
// ----------------------------------------------------------------------------
// pcv_vec_cell
// One vectoring CORDIC iteration: drives y towards zero, sums the angle.
// ----------------------------------------------------------------------------
module pcv_vec_cell
    import pcv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [STAGE_IDX_W-1:0] idx,
    input  vec_t                   din,
    output vec_t                   dout
);

    vec_t cell_reg;
    vec_t cell_next;

    // micro-rotation by the sign of y
    always_comb
    begin
        cell_next = din;
        if (din.y >= 0)
        begin
            cell_next.x   = din.x + (din.y >>> idx);
            cell_next.y   = din.y - (din.x >>> idx);
            cell_next.acc = din.acc + atan_turn(idx);
        end
        else
        begin
            cell_next.x   = din.x - (din.y >>> idx);
            cell_next.y   = din.y + (din.x >>> idx);
            cell_next.acc = din.acc - atan_turn(idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== design/pcv_rot_cell.sv =====
// ----------------------------------------------------------------------------
// pcv_rot_cell
// One rotating CORDIC iteration: turns the vector, drives z towards zero.
// ----------------------------------------------------------------------------
module pcv_rot_cell
    import pcv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [STAGE_IDX_W-1:0] idx,
    input  rot_t                   din,
    output rot_t                   dout
);

    rot_t cell_reg;
    rot_t cell_next;
    logic signed [ZW-1:0] step;

    assign step = $signed({{(ZW-32){1'b0}}, atan_turn(idx)});

    // micro-rotation by the sign of the residual angle
    always_comb
    begin
        cell_next = din;
        if (din.z >= 0)
        begin
            cell_next.x = din.x - (din.y >>> idx);
            cell_next.y = din.y + (din.x >>> idx);
            cell_next.z = din.z - step;
        end
        else
        begin
            cell_next.x = din.x + (din.y >>> idx);
            cell_next.y = din.y - (din.x >>> idx);
            cell_next.z = din.z + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== design/pcv_gain_mul.sv =====
// ----------------------------------------------------------------------------
// pcv_gain_mul
// Two-stage multiply by the Q31 inverse CORDIC gain, rounded half up.
// ----------------------------------------------------------------------------
module pcv_gain_mul
    import pcv_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] a,
    output logic [VW-1:0] p
);

    localparam int HI_W = VW - 31;

    logic [HI_W+31:0] hi_prod;
    logic [62:0]      lo_prod;
    logic [VW-1:0]    hi_reg;
    logic [31:0]      lo_reg;
    logic [VW-1:0]    p_reg;

    // partial products on the upper and lower parts of a
    assign hi_prod = a[VW-1:31] * INV_K;
    assign lo_prod = a[30:0] * INV_K + 63'h40000000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg <= hi_prod[VW-1:0];
            lo_reg <= lo_prod[62:31];
            p_reg  <= hi_reg + {{(VW-32){1'b0}}, lo_reg};
        end
    end

    assign p = p_reg;

endmodule

// ===== design/polar_clamp_vector.sv =====
// ----------------------------------------------------------------------------
// polar_clamp_vector
// Length and sector clamp of a relative vector through two CORDIC rows.
// ----------------------------------------------------------------------------
// Usage:
//   point  : one word per point (abs_x/abs_y, ref_x/ref_y, Q16.16 signed).
//   result : one word per point (out_x/out_y, Q16.16 signed, saturated).
//   cfg    : register writes, index 0..3, always ready; write only while idle.
// Path: stage 0, the fold registers, two rows of 16 CORDIC cells, two gain
//   multipliers, the clamp register and the output register.
// Throughput: one point per cycle, every cell takes a new word each cycle, unless stalled.
// Stalls: a two-entry output (last stage plus skid register) absorbs one
//   stalled word; while the skid holds a word the whole row freezes and
//   point.ready is low. point.ready is a register output.
// Reset: all valid flags clear, length limits go to zero (disabled) and
//   the sector opens to the full turn.
// ----------------------------------------------------------------------------
module polar_clamp_vector
    import pcv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pcv_point_if.sink    point,
    pcv_result_if.source result,
    pcv_cfg_if.sink      cfg
);

    logic adv;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_CFG_W-1:0] floor_reg;
    logic [LEN_CFG_W-1:0] ceil_reg;
    logic [ANG_CFG_W-1:0] low_reg;
    logic [ANG_CFG_W-1:0] high_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
            ceil_reg  <= '0;
            low_reg   <= '0;
            high_reg  <= ANGLE_HIGH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_LENGTH_FLOOR:   floor_reg <= cfg.data[LEN_CFG_W-1:0];
                REG_LENGTH_CEILING: ceil_reg  <= cfg.data[LEN_CFG_W-1:0];
                REG_ANGLE_LOW:      low_reg   <= cfg.data[ANG_CFG_W-1:0];
                REG_ANGLE_HIGH:     high_reg  <= cfg.data[ANG_CFG_W-1:0];
                default:            floor_reg <= floor_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: relative vector, saturated
    // ------------------------------------------------------------------
    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic signed [COORD_W-1:0] sat_x;
    logic signed [COORD_W-1:0] sat_y;
    logic                      s0_v_reg;
    logic signed [COORD_W-1:0] s0_x_reg;
    logic signed [COORD_W-1:0] s0_y_reg;

    assign point.ready = adv;
    assign diff_x = {point.abs_x[COORD_W-1], point.abs_x}
                  - {point.ref_x[COORD_W-1], point.ref_x};
    assign diff_y = {point.abs_y[COORD_W-1], point.abs_y}
                  - {point.ref_y[COORD_W-1], point.ref_y};

    always_comb
    begin
        sat_x = diff_x[COORD_W-1:0];
        if (diff_x[COORD_W] != diff_x[COORD_W-1])
            sat_x = diff_x[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                    : {1'b0, {(COORD_W-1){1'b1}}};
        sat_y = diff_y[COORD_W-1:0];
        if (diff_y[COORD_W] != diff_y[COORD_W-1])
            sat_y = diff_y[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                    : {1'b0, {(COORD_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (adv)
            s0_v_reg <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x_reg <= sat_x;
            s0_y_reg <= sat_y;
        end
    end

    // ------------------------------------------------------------------
    // Half-plane fold into the vectoring row
    // ------------------------------------------------------------------
    vec_t vchain [0:N_STAGES];
    vec_t fold_next;
    logic signed [VW-1:0] gx;
    logic signed [VW-1:0] gy;

    assign gx = {{(VW-COORD_W-GUARD_BITS){s0_x_reg[COORD_W-1]}}, s0_x_reg,
                 {GUARD_BITS{1'b0}}};
    assign gy = {{(VW-COORD_W-GUARD_BITS){s0_y_reg[COORD_W-1]}}, s0_y_reg,
                 {GUARD_BITS{1'b0}}};

    always_comb
    begin
        fold_next.valid = s0_v_reg;
        fold_next.zero  = (s0_x_reg == '0) && (s0_y_reg == '0);
        fold_next.x     = gx;
        fold_next.y     = gy;
        fold_next.acc   = 32'h0;
        if (gx < 0)
        begin
            fold_next.x   = -gx;
            fold_next.y   = -gy;
            fold_next.acc = 32'h80000000;
        end
    end

    vec_t fold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_reg.valid <= 1'b0;
        else if (adv)
            fold_reg <= fold_next;
    end

    assign vchain[0] = fold_reg;

    // Vectoring row
    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_vec
        pcv_vec_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .idx   (STAGE_IDX_W'(i)),
            .din   (vchain[i]),
            .dout  (vchain[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Length scaling and angle rounding
    // ------------------------------------------------------------------
    logic [VW-1:0]      len_raw;
    logic [31:0]        ang_sum;
    logic [1:0]         m1_v_reg;
    logic [1:0]         m1_z_reg;
    logic [ANGLE_W-1:0] m1_ang0_reg;
    logic [ANGLE_W-1:0] m1_ang1_reg;

    pcv_gain_mul u_mul_len (
        .clk (clk),
        .en  (adv),
        .a   (vchain[N_STAGES].x),
        .p   (len_raw)
    );

    assign ang_sum = vchain[N_STAGES].acc + 32'h00008000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_v_reg <= '0;
        else if (adv)
            m1_v_reg <= {m1_v_reg[0], vchain[N_STAGES].valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_z_reg    <= {m1_z_reg[0], vchain[N_STAGES].zero};
            m1_ang0_reg <= vchain[N_STAGES].zero ? '0 : ang_sum[31:32-ANGLE_W];
            m1_ang1_reg <= m1_ang0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Length and sector clamp
    // ------------------------------------------------------------------
    logic [VW-1:0]        len_in;
    logic [VW-1:0]        len_f;
    logic [VW-1:0]        len_c;
    logic [VW-1:0]        floor_ext;
    logic [VW-1:0]        ceil_ext;
    logic [ANG_CFG_W-1:0] ang_ext;
    logic [ANG_CFG_W-1:0] d_hi;
    logic [ANG_CFG_W-1:0] d_lo;
    logic [ANG_CFG_W-1:0] ang_snap;
    logic                 in_sector;
    logic                 cl_v_reg;
    logic [VW-1:0]        cl_len_reg;
    logic [ANGLE_W-1:0]   cl_ang_reg;

    assign len_in    = m1_z_reg[1] ? '0 : len_raw;
    assign floor_ext = {{(VW-LEN_CFG_W-GUARD_BITS){1'b0}}, floor_reg, {GUARD_BITS{1'b0}}};
    assign ceil_ext  = {{(VW-LEN_CFG_W-GUARD_BITS){1'b0}}, ceil_reg, {GUARD_BITS{1'b0}}};
    assign len_f     = (floor_reg != '0 && len_in < floor_ext) ? floor_ext : len_in;
    assign len_c     = (ceil_reg != '0 && len_f > ceil_ext) ? ceil_ext : len_f;
    assign ang_ext   = {1'b0, m1_ang1_reg};

    always_comb
    begin
        if (low_reg > high_reg)
            in_sector = (ang_ext >= low_reg) || (ang_ext < high_reg);
        else
            in_sector = (ang_ext > low_reg) && (ang_ext < high_reg);
        d_hi = (high_reg > ang_ext) ? high_reg - ang_ext : ang_ext - high_reg;
        d_lo = (low_reg > ang_ext) ? low_reg - ang_ext : ang_ext - low_reg;
        ang_snap = ang_ext;
        if (!in_sector)
            ang_snap = (d_hi < d_lo) ? high_reg : low_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cl_v_reg <= 1'b0;
        else if (adv)
            cl_v_reg <= m1_v_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl_len_reg <= len_c;
            cl_ang_reg <= ang_snap[ANGLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pre-scale for the rotating row
    // ------------------------------------------------------------------
    logic [VW-1:0]      len_scaled;
    logic [1:0]         m2_v_reg;
    logic [ANGLE_W-1:0] m2_ang0_reg;
    logic [ANGLE_W-1:0] m2_ang1_reg;

    pcv_gain_mul u_mul_rot (
        .clk (clk),
        .en  (adv),
        .a   (cl_len_reg),
        .p   (len_scaled)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_v_reg <= '0;
        else if (adv)
            m2_v_reg <= {m2_v_reg[0], cl_v_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_ang0_reg <= cl_ang_reg;
            m2_ang1_reg <= m2_ang0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Quadrant fold into the rotating row
    // ------------------------------------------------------------------
    rot_t        rchain [0:N_STAGES];
    rot_t        rfold_next;
    rot_t        rfold_reg;
    logic [31:0] turn;
    logic [31:0] turn_f;

    assign turn = {m2_ang1_reg, {(32-ANGLE_W){1'b0}}};

    always_comb
    begin
        rfold_next.valid = m2_v_reg[1];
        rfold_next.x     = $signed(len_scaled);
        rfold_next.y     = '0;
        turn_f           = turn;
        if (turn > 32'h40000000 && turn < 32'hC0000000)
        begin
            rfold_next.x = -$signed(len_scaled);
            turn_f       = turn + 32'h80000000;
        end
        rfold_next.z = {{(ZW-32){turn_f[31]}}, turn_f};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rfold_reg.valid <= 1'b0;
        else if (adv)
            rfold_reg <= rfold_next;
    end

    assign rchain[0] = rfold_reg;

    // Rotating row
    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_rot
        pcv_rot_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .idx   (STAGE_IDX_W'(i)),
            .din   (rchain[i]),
            .dout  (rchain[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: drop guard bits (half up) and saturate
    // ------------------------------------------------------------------
    localparam int RW = VW - GUARD_BITS;
    localparam logic signed [VW-1:0] RND = VW'(1) << (GUARD_BITS - 1);

    logic signed [VW-1:0]      rnd_x;
    logic signed [VW-1:0]      rnd_y;
    logic signed [RW-1:0]      sh_x;
    logic signed [RW-1:0]      sh_y;
    logic signed [COORD_W-1:0] o_x;
    logic signed [COORD_W-1:0] o_y;
    logic                      os_v_reg;
    logic signed [COORD_W-1:0] os_x_reg;
    logic signed [COORD_W-1:0] os_y_reg;

    assign rnd_x = rchain[N_STAGES].x + RND;
    assign rnd_y = rchain[N_STAGES].y + RND;
    assign sh_x  = rnd_x[VW-1:GUARD_BITS];
    assign sh_y  = rnd_y[VW-1:GUARD_BITS];

    always_comb
    begin
        o_x = sh_x[COORD_W-1:0];
        if (sh_x > $signed({{(RW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}}))
            o_x = {1'b0, {(COORD_W-1){1'b1}}};
        else if (sh_x < $signed({{(RW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
            o_x = {1'b1, {(COORD_W-1){1'b0}}};
        o_y = sh_y[COORD_W-1:0];
        if (sh_y > $signed({{(RW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}}))
            o_y = {1'b0, {(COORD_W-1){1'b1}}};
        else if (sh_y < $signed({{(RW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
            o_y = {1'b1, {(COORD_W-1){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            os_v_reg <= 1'b0;
        else if (adv)
            os_v_reg <= rchain[N_STAGES].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            os_x_reg <= o_x;
            os_y_reg <= o_y;
        end
    end

    // ------------------------------------------------------------------
    // Skid register: catches the output word when the receiver stalls
    // ------------------------------------------------------------------
    logic                      skid_v_reg;
    logic                      skid_v_next;
    logic signed [COORD_W-1:0] skid_x_reg;
    logic signed [COORD_W-1:0] skid_y_reg;

    assign adv = !skid_v_reg;

    always_comb
    begin
        skid_v_next = skid_v_reg;
        if (skid_v_reg && result.ready)
            skid_v_next = 1'b0;
        else if (!skid_v_reg && os_v_reg && !result.ready)
            skid_v_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_v_reg <= 1'b0;
        else
            skid_v_reg <= skid_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_x_reg <= os_x_reg;
            skid_y_reg <= os_y_reg;
        end
    end

    assign result.valid = skid_v_reg || os_v_reg;
    assign result.out_x = skid_v_reg ? skid_x_reg : os_x_reg;
    assign result.out_y = skid_v_reg ? skid_y_reg : os_y_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "polar_clamp_vector_assert.svh"

    `PCV_ASSERT_NEXT(a_skid_holds, skid_v_reg && !result.ready,
        skid_v_reg && $stable(skid_x_reg) && $stable(skid_y_reg),
        "skid word lost while stalled")
    `PCV_ASSERT_NEXT(a_row_frozen, !adv,
        os_v_reg == $past(os_v_reg) && s0_v_reg == $past(s0_v_reg),
        "pipeline moved while frozen")
    `PCV_ASSERT_NEXT(a_floor_write, cfg.valid && cfg.index == REG_LENGTH_FLOOR,
        floor_reg == $past(cfg.data[LEN_CFG_W-1:0]),
        "length floor write not taken")

endmodule

// ===== sim/polar_clamp_vector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_clamp_vector_checker
// Watches the point, result and register channels of the polar clamp block,
// predicts each clamped vector from its own copy of the registers and
// compares every result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module polar_clamp_vector_checker
    import pcv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    pcv_point_if   point,
    pcv_result_if  result,
    pcv_cfg_if     cfg,
    output int     errors,
    output int     pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } vec_word_t;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    // Register copy
    logic [30:0] floor_len;
    logic [30:0] ceil_len;
    logic [16:0] sector_lo;
    logic [16:0] sector_hi;

    vec_word_t      clamped_q[$];
    longint unsigned gain_inv;

    function automatic logic [31:0] turn_atan(int i);
        logic [31:0] tab [0:15];
        tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
        return tab[i];
    endfunction

    function automatic longint clip32(longint v);
        return v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v);
    endfunction

    // (a * k + 2^30) >> 31, split to stay within 64 bits
    function automatic longint unsigned q31_scale(longint unsigned a,
                                                  longint unsigned k);
        longint unsigned ah;
        longint unsigned al;
        ah = a >> 31;
        al = a & 64'h7FFF_FFFF;
        return ah * k + ((al * k + 64'h4000_0000) >> 31);
    endfunction

    // Vectoring row: rotates (x, y) onto the x axis, returns the angle
    function automatic logic [31:0] to_polar(inout longint x, inout longint y);
        logic [31:0] acc;
        longint      sx;
        longint      sy;
        acc = 32'h0;
        if (x < 0)
        begin
            x   = -x;
            y   = -y;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++)
        begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0)
            begin
                x   = x + sx;
                y   = y - sy;
                acc = acc + turn_atan(i);
            end
            else
            begin
                x   = x - sx;
                y   = y + sy;
                acc = acc - turn_atan(i);
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned calc_gain_inv();
        longint          x;
        longint          y;
        logic [31:0]     unused;
        longint unsigned g;
        x = longint'(1) << 30;
        y = 0;
        unused = to_polar(x, y);
        g = x;
        return ((64'd1 << 61) + g / 2) / g;
    endfunction

    function automatic logic signed [31:0] drop_guard(longint v);
        return 32'(clip32((v + 8) >>> 4));
    endfunction

    function automatic vec_word_t clamp_vector(logic signed [31:0] ax,
                                               logic signed [31:0] ay,
                                               logic signed [31:0] rx,
                                               logic signed [31:0] ry);
        vec_word_t       w;
        longint          dx;
        longint          dy;
        longint          vx;
        longint          vy;
        logic [31:0]     acc;
        longint unsigned len;
        longint unsigned ang;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned d_lo;
        longint unsigned d_hi;
        logic            in_sector;
        logic [31:0]     t;
        longint          z;
        longint          x;
        longint          y;
        longint          sx;
        longint          sy;

        dx  = clip32(longint'(ax) - longint'(rx));
        dy  = clip32(longint'(ay) - longint'(ry));
        vx  = dx * 16;
        vy  = dy * 16;
        acc = to_polar(vx, vy);
        len = q31_scale(longint'(vx), gain_inv);
        if (dx == 0 && dy == 0)
        begin
            ang = 0;
            len = 0;
        end
        else
            ang = ((longint'(acc) + (64'd1 << 15)) >> 16) & 64'hFFFF;

        // Length limits: floor first, ceiling wins
        if (floor_len != 0 && len < (longint'(floor_len) << 4))
            len = longint'(floor_len) << 4;
        if (ceil_len != 0 && len > (longint'(ceil_len) << 4))
            len = longint'(ceil_len) << 4;

        // Sector check and snap, ties to the low edge
        lo = sector_lo;
        hi = sector_hi;
        if (lo > hi)
            in_sector = (ang >= lo) || (ang < hi);
        else
            in_sector = (ang > lo) && (ang < hi);
        if (!in_sector)
        begin
            d_hi = hi > ang ? hi - ang : ang - hi;
            d_lo = lo > ang ? lo - ang : ang - lo;
            ang  = d_hi < d_lo ? hi : lo;
        end

        // Rotating row rebuilds the vector
        x = longint'(q31_scale(len, gain_inv));
        y = 0;
        t = 32'(ang << 16);
        if (t > 32'h4000_0000 && t < 32'hC000_0000)
        begin
            x = -x;
            t = t + 32'h8000_0000;
        end
        z = longint'($signed(t));
        for (int i = 0; i < 16; i++)
        begin
            sx = y >>> i;
            sy = x >>> i;
            if (z >= 0)
            begin
                x = x - sx;
                y = y + sy;
                z = z - longint'(turn_atan(i));
            end
            else
            begin
                x = x + sx;
                y = y - sy;
                z = z + longint'(turn_atan(i));
            end
        end
        w.x = drop_guard(x);
        w.y = drop_guard(y);
        return w;
    endfunction

    initial gain_inv = calc_gain_inv();

    assign pending = clamped_q.size();

    // Register writes, point predictions and result compare
    always @(posedge clk or negedge rst_n)
    begin
        vec_word_t exp_w;
        if (!rst_n)
        begin
            floor_len <= '0;
            ceil_len  <= '0;
            sector_lo <= '0;
            sector_hi <= ANGLE_HIGH_RESET;
            errors    <= 0;
            clamped_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_LENGTH_FLOOR:   floor_len <= cfg.data[30:0];
                    REG_LENGTH_CEILING: ceil_len  <= cfg.data[30:0];
                    REG_ANGLE_LOW:      sector_lo <= cfg.data[16:0];
                    REG_ANGLE_HIGH:     sector_hi <= cfg.data[16:0];
                    default: ;
                endcase
            end
            if (point.valid && point.ready)
                clamped_q.push_back(clamp_vector(point.abs_x, point.abs_y,
                                                 point.ref_x, point.ref_y));
            if (result.valid && result.ready)
            begin
                if (clamped_q.size() == 0)
                begin
                    $error("result word with no prediction: x=%0d y=%0d",
                           result.out_x, result.out_y);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_w = clamped_q.pop_front();
                    if (result.out_x !== exp_w.x || result.out_y !== exp_w.y)
                    begin
                        if (result.out_x !== exp_w.x)
                            $error("out_x: expected %0d, actual %0d",
                                   exp_w.x, result.out_x);
                        if (result.out_y !== exp_w.y)
                            $error("out_y: expected %0d, actual %0d",
                                   exp_w.y, result.out_y);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/polar_clamp_vector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_clamp_vector_tb
// Drives points through the polar clamp block over several register settings
// (open sector, strict and wrapping sectors, closed sector, length limits at
// their extremes) with random stalls on both sides; a checker judges results.
// ----------------------------------------------------------------------------
module polar_clamp_vector_tb;
    import pcv_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_pct;
    int   sent;
    int   watchdog;
    int   phases_done;

    pcv_point_if  point ();
    pcv_result_if result ();
    pcv_cfg_if    cfg ();

    polar_clamp_vector i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .result (result),
        .cfg    (cfg)
    );

    polar_clamp_vector_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point),
        .result  (result),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n)
            watchdog <= 0;
        else
        begin
            if ((point.valid && point.ready) || (result.valid && result.ready))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        logic got;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
        begin
            @(negedge clk);
            got = cfg.ready;
            @(posedge clk);
        end
        while (!got);
        cfg.valid <= 1'b0;
    endtask

    // Offers one point word; valid stays high into the next word
    task automatic send_point(logic [31:0] ax, logic [31:0] ay,
                              logic [31:0] rx, logic [31:0] ry);
        logic got;
        while ($urandom_range(99) < idle_pct)
        begin
            point.valid <= 1'b0;
            @(posedge clk);
        end
        point.valid <= 1'b1;
        point.abs_x <= ax;
        point.abs_y <= ay;
        point.ref_x <= rx;
        point.ref_y <= ry;
        do
        begin
            @(negedge clk);
            got = point.ready;
            @(posedge clk);
        end
        while (!got);
        sent++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(2000000)) - 1000000);
            2:       return 32'($signed($urandom_range(200)) - 100);
            default: return {{16{$urandom_range(1)==1}}, 16'($urandom)};
        endcase
    endfunction

    task automatic random_points(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            else
                send_point(rand_coord(), rand_coord(), 32'h0, 32'h0);
        end
    endtask

    // Lets the pipe empty before registers change
    task automatic drain();
        point.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] fl, logic [31:0] cl,
                            logic [31:0] lo, logic [31:0] hi);
        write_reg(REG_LENGTH_FLOOR, fl);
        write_reg(REG_LENGTH_CEILING, cl);
        write_reg(REG_ANGLE_LOW, lo);
        write_reg(REG_ANGLE_HIGH, hi);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        idle_pct    = 17;
        sent        = 0;
        phases_done = 0;
        point.valid = 1'b0;
        point.abs_x = '0;
        point.abs_y = '0;
        point.ref_x = '0;
        point.ref_y = '0;
        cfg.valid   = 1'b0;
        cfg.index   = REG_LENGTH_FLOOR;
        cfg.data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, extremes, axes, zero vector, saturation
        send_point(32'h0, 32'h0, 32'h0, 32'h0);
        send_point(32'h5, 32'h5, 32'h5, 32'h5);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
        send_point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
        send_point(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_point(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_point(32'hFFFF_0000, 32'h0, 32'h0, 32'h0);
        send_point(32'h0, 32'hFFFF_0000, 32'h0, 32'h0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_point(32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0);
        send_point(32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
        random_points(40);
        drain();
        phases_done++;

        // Strict sector, both length limits
        set_regs(32'h0001_0000, 32'h0010_0000, 32'd8000, 32'd30000);
        send_point(32'h0, 32'h0, 32'h0, 32'h0);
        send_point(32'h0100_0000, 32'h0, 32'h0, 32'h0);
        send_point(32'h10, 32'hFFFF_FFF0, 32'h0, 32'h0);
        random_points(50);
        drain();
        phases_done++;

        // Wrapping sector, no idling at all
        idle_pct = 0;
        set_regs(32'h0, 32'h0, 32'd50000, 32'd12000);
        random_points(70);
        drain();
        idle_pct = 17;
        phases_done++;

        // Closed sector, floor above ceiling
        set_regs(32'h7FFF_FFFF, 32'h1, 32'd16384, 32'd16384);
        random_points(45);
        drain();
        phases_done++;

        // Edges beyond a full turn and junk in the unused data bits
        set_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFE_0000);
        random_points(30);
        drain();
        set_regs(32'h0, 32'h7FFF_FFFF, 32'd65536, 32'd70000);
        random_points(30);
        drain();
        phases_done++;

        // Random settings
        for (int p = 0; p < 4; p++)
        begin
            set_regs($urandom_range(1) ? $urandom : 32'h0,
                     $urandom_range(1) ? $urandom : 32'h0,
                     $urandom_range(65536), $urandom_range(65536));
            random_points(35);
            drain();
            phases_done++;
        end

        $display("Sent %0d points over %0d register settings, stalls on both sides.",
                 sent, phases_done);
        $display("Covered open, strict, wrapping and closed sectors and length limits.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
